// ===== hw/rtl/pwmhl_pkg.sv =====
// Shared constants and types for the PWM high/low time capture unit.
package pwmhl_pkg;

  localparam int unsigned CountWidth  = 16;
  localparam int unsigned PeriodWidth = CountWidth + 1;
  localparam int unsigned TimeW       = 16;
  localparam int unsigned PeriodOutW  = 17;
  localparam int unsigned DutyW       = 7;
  localparam int unsigned ScaleW      = 30;
  localparam int unsigned Percent     = 100;
  localparam int unsigned DutyDivW    = CountWidth + DutyW;
  localparam int unsigned DivW        = (DutyDivW > ScaleW) ? DutyDivW : ScaleW;
  localparam int unsigned DivCntW     = $clog2(DivW);
  localparam int unsigned InDataW     = 8;
  localparam int unsigned OutRawW     = 2 * TimeW + PeriodOutW + DutyW + ScaleW;
  localparam int unsigned OutDataW    = ((OutRawW + 7) / 8) * 8;
  localparam int unsigned OutUserW    = 2;

  localparam logic [ScaleW-1:0] ScaleReset = ScaleW'(1000000);

  typedef enum logic [1:0] {
    PhaseWait = 2'd0,
    PhaseHigh = 2'd1,
    PhaseLow  = 2'd2
  } phase_e;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StCheck = 5'b00010,
    StDuty  = 5'b00100,
    StFreq  = 5'b01000,
    StWrite = 5'b10000
  } ctrl_state_e;

  typedef struct packed {
    logic step;
    logic load_duty;
    logic div_step;
    logic duty_done;
    logic freq_done;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic calc_go;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

// ===== hw/rtl/pwm_high_low_time_capture_unit.sv =====
// Top level of the PWM high/low time capture unit.
//
//   channel  | direction | payload
//   ---------+-----------+-----------------------------------------------------
//   s_axis   | in        | tdata[0] pin_level
//   m_axis   | out       | tdata: high, low, period, duty, frequency; tuser: flags
//   cfg      | in        | cfg_data_i freq_scale
//
// An item without a new high or low capture goes through accept, check and output load.
// After a capture or a freq_scale write, once both times are measured, the shared
// 1-bit-per-cycle divider runs twice (duty, then frequency) before the output load.
// Reset waits for a real rising edge; duty and frequency read 0 until measured.
// A result waiting in the output register does not block the next input item.
module pwm_high_low_time_capture_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [pwmhl_pkg::InDataW-1:0]      s_axis_tdata_i,  // [0] pin_level
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [15:0] high_time, [31:16] low_time, [48:32] period_ticks,
  // [55:49] duty_percent, [85:56] frequency
  output logic [pwmhl_pkg::OutDataW-1:0]     m_axis_tdata_o,
  output logic [pwmhl_pkg::OutUserW-1:0]     m_axis_tuser_o,  // [0] measured, [1] overflow
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pwmhl_pkg::ScaleW-1:0]       cfg_data_i       // freq_scale
);

  pwmhl_pkg::cmd_t    cmd;
  pwmhl_pkg::status_t status;
  logic               cfg_we;

  assign cfg_we = cfg_valid_i & cfg_ready_o;

  pwmhl_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .cfg_ready_o     (cfg_ready_o),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  pwmhl_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .pin_level_i (s_axis_tdata_i[0]),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data_i),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_data_o    (m_axis_tdata_o),
    .m_user_o    (m_axis_tuser_o)
  );

endmodule

// ===== hw/rtl/pwmhl_ctrl.sv =====
// Controller state machine: sequences sample update, divisions and output load.
module pwmhl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  output logic               cfg_ready_o,
  input  pwmhl_pkg::status_t status_i,
  output pwmhl_pkg::cmd_t    cmd_o
);

  pwmhl_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pwmhl_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_axis_tready_o = (state_q == pwmhl_pkg::StIdle);
  assign cfg_ready_o     = (state_q == pwmhl_pkg::StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      pwmhl_pkg::StIdle: begin
        if (s_axis_tvalid_i) begin
          cmd_o.step = 1'b1;
          state_d    = pwmhl_pkg::StCheck;
        end
      end
      pwmhl_pkg::StCheck: begin
        if (status_i.calc_go) begin
          cmd_o.load_duty = 1'b1;
          state_d         = pwmhl_pkg::StDuty;
        end else begin
          state_d = pwmhl_pkg::StWrite;
        end
      end
      pwmhl_pkg::StDuty: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          cmd_o.duty_done = 1'b1;
          state_d         = pwmhl_pkg::StFreq;
        end
      end
      pwmhl_pkg::StFreq: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          cmd_o.freq_done = 1'b1;
          state_d         = pwmhl_pkg::StWrite;
        end
      end
      pwmhl_pkg::StWrite: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = pwmhl_pkg::StIdle;
        end
      end
      default: begin
        state_d = pwmhl_pkg::StIdle;
      end
    endcase
  end

endmodule

// ===== hw/rtl/pwmhl_datapath.sv =====
// Datapath: edge capture, tick counter, shared restoring divider, output register.
module pwmhl_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pwmhl_pkg::cmd_t                     cmd_i,
  output pwmhl_pkg::status_t                  status_o,
  input  logic                                pin_level_i,
  input  logic                                cfg_we_i,
  input  logic [pwmhl_pkg::ScaleW-1:0]        cfg_data_i,
  output logic                                m_valid_o,
  input  logic                                m_ready_i,
  output logic [pwmhl_pkg::OutDataW-1:0]      m_data_o,
  output logic [pwmhl_pkg::OutUserW-1:0]      m_user_o
);

  localparam logic [pwmhl_pkg::CountWidth-1:0] CountTop = '1;

  pwmhl_pkg::phase_e                   phase_q, phase_d;
  logic [pwmhl_pkg::CountWidth-1:0]    tick_q, tick_d;
  logic [pwmhl_pkg::CountWidth-1:0]    high_q, high_d;
  logic [pwmhl_pkg::CountWidth-1:0]    low_q, low_d;
  logic                                prev_q, prev_d;
  logic                                have_high_q, have_high_d;
  logic                                have_low_q, have_low_d;
  logic                                sat_q, sat_d;
  logic                                recalc_q, recalc_d;
  logic [pwmhl_pkg::ScaleW-1:0]        scale_q, scale_d;
  logic [pwmhl_pkg::DutyW-1:0]         duty_q, duty_d;
  logic [pwmhl_pkg::ScaleW-1:0]        freq_q, freq_d;

  logic [pwmhl_pkg::PeriodWidth-1:0]   rem_q, rem_d;
  logic [pwmhl_pkg::DivW-1:0]          quo_q, quo_d;
  logic [pwmhl_pkg::DivCntW-1:0]       cnt_q, cnt_d;

  logic                                m_valid_q, m_valid_d;
  logic [pwmhl_pkg::OutDataW-1:0]      m_data_q, m_data_d;
  logic [pwmhl_pkg::OutUserW-1:0]      m_user_q, m_user_d;

  logic                                rising, falling, cap, measured;
  logic [pwmhl_pkg::PeriodWidth-1:0]   period;
  logic [pwmhl_pkg::PeriodWidth:0]     rem_sh;
  logic                                q_bit;
  logic [pwmhl_pkg::PeriodWidth-1:0]   rem_next;
  logic [pwmhl_pkg::DivW-1:0]          quo_next;

  assign rising   = pin_level_i & ~prev_q;
  assign falling  = ~pin_level_i & prev_q;
  assign measured = have_high_q & have_low_q;
  assign period   = pwmhl_pkg::PeriodWidth'(high_q) + pwmhl_pkg::PeriodWidth'(low_q);

  // one restoring division step
  assign rem_sh   = {rem_q, quo_q[pwmhl_pkg::DivW-1]};
  assign q_bit    = (rem_sh >= {1'b0, period});
  assign rem_next = q_bit ? pwmhl_pkg::PeriodWidth'(rem_sh - {1'b0, period})
                          : pwmhl_pkg::PeriodWidth'(rem_sh);
  assign quo_next = {quo_q[pwmhl_pkg::DivW-2:0], q_bit};

  assign status_o.calc_go  = recalc_q & measured & (period != '0);
  assign status_o.div_last = (cnt_q == pwmhl_pkg::DivCntW'(pwmhl_pkg::DivW - 1));
  assign status_o.out_free = ~m_valid_q | m_ready_i;

  always_comb begin
    phase_d     = phase_q;
    tick_d      = tick_q;
    high_d      = high_q;
    low_d       = low_q;
    prev_d      = prev_q;
    have_high_d = have_high_q;
    have_low_d  = have_low_q;
    sat_d       = sat_q;
    recalc_d    = recalc_q;
    cap         = 1'b0;

    if (cmd_i.step) begin
      unique case (phase_q)
        pwmhl_pkg::PhaseHigh: begin
          if (falling) begin
            high_d      = tick_q;
            have_high_d = 1'b1;
            phase_d     = pwmhl_pkg::PhaseLow;
            cap         = 1'b1;
            recalc_d    = 1'b1;
          end
        end
        pwmhl_pkg::PhaseLow: begin
          if (rising) begin
            low_d      = tick_q;
            have_low_d = 1'b1;
            phase_d    = pwmhl_pkg::PhaseHigh;
            cap        = 1'b1;
            recalc_d   = 1'b1;
          end
        end
        default: begin
          if (rising) begin
            phase_d = pwmhl_pkg::PhaseHigh;
            cap     = 1'b1;
          end
        end
      endcase

      priority if (cap) begin
        tick_d = pwmhl_pkg::CountWidth'(1);
        sat_d  = 1'b0;
      end else if (phase_q == pwmhl_pkg::PhaseHigh || phase_q == pwmhl_pkg::PhaseLow) begin
        if (tick_q == CountTop) begin
          sat_d = 1'b1;
        end else begin
          tick_d = tick_q + pwmhl_pkg::CountWidth'(1);
        end
      end else begin
        tick_d = '0;
      end
      prev_d = pin_level_i;
    end

    if (cfg_we_i) begin
      recalc_d = 1'b1;
    end
    if (cmd_i.freq_done) begin
      recalc_d = 1'b0;
    end
  end

  assign scale_d = cfg_we_i ? cfg_data_i : scale_q;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    duty_d = duty_q;
    freq_d = freq_q;
    priority if (cmd_i.load_duty) begin
      rem_d = '0;
      quo_d = pwmhl_pkg::DivW'(high_q) * pwmhl_pkg::DivW'(pwmhl_pkg::Percent);
      cnt_d = '0;
    end else if (cmd_i.duty_done) begin
      duty_d = pwmhl_pkg::DutyW'(quo_next);
      rem_d  = '0;
      quo_d  = pwmhl_pkg::DivW'(scale_q);
      cnt_d  = '0;
    end else if (cmd_i.freq_done) begin
      freq_d = pwmhl_pkg::ScaleW'(quo_next);
    end else if (cmd_i.div_step) begin
      rem_d = rem_next;
      quo_d = quo_next;
      cnt_d = cnt_q + pwmhl_pkg::DivCntW'(1);
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
    if (cmd_i.load_out) begin
      m_valid_d = 1'b1;
      m_data_d  = pwmhl_pkg::OutDataW'({freq_q, duty_q,
                                        pwmhl_pkg::PeriodOutW'(period),
                                        pwmhl_pkg::TimeW'(low_q),
                                        pwmhl_pkg::TimeW'(high_q)});
      m_user_d  = {sat_q, measured};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= pwmhl_pkg::PhaseWait;
      tick_q      <= '0;
      high_q      <= '0;
      low_q       <= '0;
      prev_q      <= 1'b1;
      have_high_q <= 1'b0;
      have_low_q  <= 1'b0;
      sat_q       <= 1'b0;
      recalc_q    <= 1'b0;
      scale_q     <= pwmhl_pkg::ScaleReset;
      duty_q      <= '0;
      freq_q      <= '0;
      cnt_q       <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      tick_q      <= tick_d;
      high_q      <= high_d;
      low_q       <= low_d;
      prev_q      <= prev_d;
      have_high_q <= have_high_d;
      have_low_q  <= have_low_d;
      sat_q       <= sat_d;
      recalc_q    <= recalc_d;
      scale_q     <= scale_d;
      duty_q      <= duty_d;
      freq_q      <= freq_d;
      cnt_q       <= cnt_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_user_o  = m_user_q;

endmodule

// ===== dv/testbench.sv =====
// Self-checking stream testbench for the PWM high/low time capture unit.
module testbench;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned DrainWait  = 70;

  typedef struct packed {
    logic [pwmhl_pkg::TimeW-1:0]      high_time;
    logic [pwmhl_pkg::TimeW-1:0]      low_time;
    logic [pwmhl_pkg::PeriodOutW-1:0] period_ticks;
    logic [pwmhl_pkg::DutyW-1:0]      duty_percent;
    logic [pwmhl_pkg::ScaleW-1:0]     frequency;
    logic                             measured;
    logic                             overflow;
  } pwm_result_t;

  logic                           clk_i           = 1'b0;
  logic                           rst_ni          = 1'b0;
  logic                           s_axis_tvalid_i = 1'b0;
  logic                           s_axis_tready_o;
  logic [pwmhl_pkg::InDataW-1:0]  s_axis_tdata_i  = '0;   // [0] pin_level
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i = 1'b0;
  // [15:0] high_time, [31:16] low_time, [48:32] period_ticks,
  // [55:49] duty_percent, [85:56] frequency
  logic [pwmhl_pkg::OutDataW-1:0] m_axis_tdata_o;
  logic [pwmhl_pkg::OutUserW-1:0] m_axis_tuser_o;         // [0] measured, [1] overflow
  logic                           cfg_valid_i     = 1'b0;
  logic                           cfg_ready_o;
  logic [pwmhl_pkg::ScaleW-1:0]   cfg_data_i      = '0;

  pwm_high_low_time_capture_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // capture-model state
  pwmhl_pkg::phase_e            cap_phase  = pwmhl_pkg::PhaseWait;
  logic [pwmhl_pkg::TimeW-1:0]  tick_cnt   = '0;
  logic [pwmhl_pkg::TimeW-1:0]  high_ticks = '0;
  logic [pwmhl_pkg::TimeW-1:0]  low_ticks  = '0;
  logic                         last_level = 1'b1;
  logic                         got_high   = 1'b0;
  logic                         got_low    = 1'b0;
  logic                         sat_flag   = 1'b0;
  logic [pwmhl_pkg::ScaleW-1:0] scale_q    = pwmhl_pkg::ScaleReset;

  bit          pending_levels[$];
  pwm_result_t expected_results[$];
  int unsigned pushed_cnt    = 0;
  int unsigned accepted_cnt  = 0;
  int unsigned err_cnt       = 0;
  int unsigned stall_cycles  = 0;
  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 47;

  function automatic pwm_result_t measure_sample(input logic level);
    pwm_result_t res;
    logic        rising;
    logic        falling;
    logic        restart;
    int unsigned period;
    rising  = level && !last_level;
    falling = !level && last_level;
    restart = 1'b0;
    if (cap_phase == pwmhl_pkg::PhaseHigh && falling) begin
      high_ticks = tick_cnt;
      got_high   = 1'b1;
      cap_phase  = pwmhl_pkg::PhaseLow;
      restart    = 1'b1;
    end else if (cap_phase == pwmhl_pkg::PhaseLow && rising) begin
      low_ticks = tick_cnt;
      got_low   = 1'b1;
      cap_phase = pwmhl_pkg::PhaseHigh;
      restart   = 1'b1;
    end else if (cap_phase == pwmhl_pkg::PhaseWait && rising) begin
      cap_phase = pwmhl_pkg::PhaseHigh;
      restart   = 1'b1;
    end
    if (restart) begin
      tick_cnt = pwmhl_pkg::TimeW'(1);
      sat_flag = 1'b0;
    end else if (cap_phase == pwmhl_pkg::PhaseHigh || cap_phase == pwmhl_pkg::PhaseLow) begin
      if (tick_cnt == '1) sat_flag = 1'b1;
      else tick_cnt = tick_cnt + 1'b1;
    end else begin
      tick_cnt = '0;
    end
    last_level = level;
    period = int'(high_ticks) + int'(low_ticks);
    res.high_time    = high_ticks;
    res.low_time     = low_ticks;
    res.period_ticks = period[pwmhl_pkg::PeriodOutW-1:0];
    res.measured     = got_high && got_low;
    res.overflow     = sat_flag;
    res.duty_percent = '0;
    res.frequency    = '0;
    if (res.measured && period != 0) begin
      res.duty_percent = pwmhl_pkg::DutyW'((int'(high_ticks) * pwmhl_pkg::Percent) / period);
      res.frequency    = pwmhl_pkg::ScaleW'(int'(scale_q) / period);
    end
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (pending_levels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= {{(pwmhl_pkg::InDataW-1){1'b0}}, pending_levels.pop_front()};
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // receiver backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin
    pwm_result_t exp_r;
    pwm_result_t act_r;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) scale_q = cfg_data_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_results.push_back(measure_sample(s_axis_tdata_i[0]));
        accepted_cnt++;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        act_r.high_time    = m_axis_tdata_o[15:0];
        act_r.low_time     = m_axis_tdata_o[31:16];
        act_r.period_ticks = m_axis_tdata_o[48:32];
        act_r.duty_percent = m_axis_tdata_o[55:49];
        act_r.frequency    = m_axis_tdata_o[85:56];
        act_r.measured     = m_axis_tuser_o[0];
        act_r.overflow     = m_axis_tuser_o[1];
        if (expected_results.size() == 0) begin
          $display("%0t mismatch item: expected none actual %h", $time, act_r);
          err_cnt++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("high_time", exp_r.high_time, act_r.high_time);
          check_field("low_time", exp_r.low_time, act_r.low_time);
          check_field("period_ticks", exp_r.period_ticks, act_r.period_ticks);
          check_field("duty_percent", exp_r.duty_percent, act_r.duty_percent);
          check_field("frequency", exp_r.frequency, act_r.frequency);
          check_field("measured", exp_r.measured, act_r.measured);
          check_field("overflow", exp_r.overflow, act_r.overflow);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_run(input bit level, input int unsigned count);
    repeat (count) begin
      pending_levels.push_back(level);
      pushed_cnt++;
    end
  endtask

  function automatic int unsigned pick_len();
    if ($urandom_range(9) < 8) return $urandom_range(6, 1);
    return $urandom_range(60, 7);
  endfunction

  task automatic push_random(input int unsigned n_items);
    int unsigned start_cnt;
    start_cnt = pushed_cnt;
    while (pushed_cnt - start_cnt < n_items) begin
      if ($urandom_range(99) < 80) begin
        push_run(1'b1, pick_len());
        push_run(1'b0, pick_len());
      end else begin
        repeat ($urandom_range(6, 1)) push_run(1'($urandom_range(1)), 1);
      end
    end
  endtask

  task automatic drain();
    while (accepted_cnt != pushed_cnt || expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_scale(input logic [pwmhl_pkg::ScaleW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // high at reset must fall and rise before timing starts
    push_run(1'b1, 2);
    push_run(1'b0, 2);
    push_run(1'b1, 3);
    push_run(1'b0, 2);
    // shortest period, then duty near both ends
    repeat (3) begin
      push_run(1'b1, 1);
      push_run(1'b0, 1);
    end
    push_run(1'b1, 6);
    push_run(1'b0, 1);
    push_run(1'b1, 1);
    push_run(1'b0, 5);
    push_run(1'b1, 1);
    drain();

    write_scale(pwmhl_pkg::ScaleW'(1));
    push_random(120);
    drain();

    send_idle_pct = 47;
    recv_idle_pct = 34;
    write_scale(pwmhl_pkg::ScaleW'(1000000000));
    push_random(60);
    drain();
    push_random(60);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_scale(pwmhl_pkg::ScaleW'($urandom_range(1000000000, 1)));
    push_random(130);
    drain();

    repeat (DrainWait) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
